>>> src/lie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_pkg
// shared constants, types and state codes of the lcp interval enumerator
// ----------------------------------------------------------------------------
package lie_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int POS_WIDTH   = 16;
    localparam int LCP_WIDTH   = 16;
    localparam int OUT_WIDTH   = 16;
    localparam int ADDR_WIDTH  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FILL_WIDTH  = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_WIDTH = LCP_WIDTH + POS_WIDTH;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EVAL
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pop;
        logic finish;
    } lie_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_hit;
        logic out_free;
    } lie_status_t;

endpackage

>>> src/lie_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/lie_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_ctrl
// sequencer: accept an entry, pop one interval per cycle unless stalled, push
// ----------------------------------------------------------------------------
module lie_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lie_pkg::lie_status_t status,
    output lie_pkg::lie_cmd_t    cmd
);

    import lie_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!status.pop_hit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EVAL:
            begin
                // a pop waits for a free output register
                cmd.pop    = status.pop_hit & status.out_free;
                cmd.finish = !status.pop_hit;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> src/lie_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lie_datapath
// interval stack with cached top, position counter and output register
// ----------------------------------------------------------------------------
module lie_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lie_pkg::lie_cmd_t                      cmd,
    output lie_pkg::lie_status_t                   status,
    input  logic [lie_pkg::LCP_WIDTH-1:0]          lcp_value,
    input  logic                                   last_item,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic [lie_pkg::OUT_WIDTH-1:0]          interval_lcp,
    output logic [lie_pkg::OUT_WIDTH-1:0]          interval_left,
    output logic [lie_pkg::OUT_WIDTH-1:0]          interval_right,
    output logic                                   run_end,
    output logic                                   stack_overflowed
);

    import lie_pkg::*;

    localparam logic [FILL_WIDTH-1:0] FILL_FULL = FILL_WIDTH'(STACK_DEPTH);
    localparam logic [FILL_WIDTH-1:0] FILL_ONE  = FILL_WIDTH'(1);
    localparam logic [FILL_WIDTH-1:0] FILL_TWO  = FILL_WIDTH'(2);

    // item registers
    logic [LCP_WIDTH-1:0]  val_reg,   val_next;
    logic                  last_reg,  last_next;
    logic [POS_WIDTH-1:0]  right_reg, right_next;
    logic [POS_WIDTH-1:0]  lb_reg,    lb_next;
    // stack control and cached top entry
    logic [POS_WIDTH-1:0]  pos_reg,   pos_next;
    logic [FILL_WIDTH-1:0] fill_reg,  fill_next;
    logic [LCP_WIDTH-1:0]  top_lcp_reg,  top_lcp_next;
    logic [POS_WIDTH-1:0]  top_left_reg, top_left_next;
    logic                  ovf_reg,   ovf_next;
    // output register
    logic                  oval_reg,  oval_next;
    logic [OUT_WIDTH-1:0]  olcp_reg,  olcp_next;
    logic [OUT_WIDTH-1:0]  oleft_reg, oleft_next;
    logic [OUT_WIDTH-1:0]  oright_reg, oright_next;
    logic                  oend_reg,  oend_next;
    logic                  oflag_reg, oflag_next;

    logic                   ram_we;
    logic [ADDR_WIDTH-1:0]  ram_waddr;
    logic [ENTRY_WIDTH-1:0] ram_wdata;
    logic [ADDR_WIDTH-1:0]  ram_raddr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;
    logic [FILL_WIDTH-1:0]  below_idx;

    logic                   below_root;
    logic [LCP_WIDTH-1:0]   below_lcp;
    logic [POS_WIDTH-1:0]   below_left;
    logic                   grows;
    logic                   push_ok;

    // stack entries 1 .. fill-1 live in the ram at their own index; the
    // read port always follows the entry just below the top
    assign below_idx = fill_next - FILL_TWO;
    assign ram_raddr = below_idx[ADDR_WIDTH-1:0];
    assign ram_we    = cmd.finish & push_ok;
    assign ram_waddr = fill_reg[ADDR_WIDTH-1:0];
    assign ram_wdata = {lb_reg, val_reg};

    lie_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // the root sits below entry 1 and is never stored
    assign below_root = (fill_reg <= FILL_TWO);
    assign below_lcp  = below_root ? '0 : ram_rdata[LCP_WIDTH-1:0];
    assign below_left = below_root ? '0 : ram_rdata[ENTRY_WIDTH-1:LCP_WIDTH];

    assign grows   = (val_reg > top_lcp_reg);
    assign push_ok = grows & (fill_reg < FILL_FULL);

    assign status.pop_hit  = (fill_reg > FILL_ONE) & (val_reg < top_lcp_reg);
    assign status.out_free = !oval_reg | out_ready;

    always_comb
    begin
        val_next      = val_reg;
        last_next     = last_reg;
        right_next    = right_reg;
        lb_next       = lb_reg;
        pos_next      = pos_reg;
        fill_next     = fill_reg;
        top_lcp_next  = top_lcp_reg;
        top_left_next = top_left_reg;
        ovf_next      = ovf_reg;
        oval_next     = oval_reg & !out_ready;
        olcp_next     = olcp_reg;
        oleft_next    = oleft_reg;
        oright_next   = oright_reg;
        oend_next     = oend_reg;
        oflag_next    = oflag_reg;

        if (cmd.load)
        begin
            val_next   = lcp_value;
            last_next  = last_item;
            right_next = pos_reg - POS_WIDTH'(1);
            lb_next    = pos_reg - POS_WIDTH'(1);
        end

        if (cmd.pop)
        begin
            // close the top interval; a pop never meets a full-stack push,
            // so the flag seen now is the flag after this entry
            oval_next     = 1'b1;
            olcp_next     = OUT_WIDTH'(top_lcp_reg);
            oleft_next    = OUT_WIDTH'(top_left_reg);
            oright_next   = OUT_WIDTH'(right_reg);
            oend_next     = (fill_reg == FILL_TWO) | !(val_reg < below_lcp);
            oflag_next    = ovf_reg;
            lb_next       = top_left_reg;
            top_lcp_next  = below_lcp;
            top_left_next = below_left;
            fill_next     = fill_reg - FILL_ONE;
        end

        if (cmd.finish)
        begin
            if (push_ok)
            begin
                top_lcp_next  = val_reg;
                top_left_next = lb_reg;
                fill_next     = fill_reg + FILL_ONE;
            end
            else if (grows)
            begin
                ovf_next = 1'b1;
            end

            if (last_reg)
            begin
                // end of run: drop open intervals, back to the root
                fill_next     = FILL_ONE;
                top_lcp_next  = '0;
                top_left_next = '0;
                pos_next      = POS_WIDTH'(1);
            end
            else
            begin
                pos_next = pos_reg + POS_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_WIDTH'(1);
            fill_reg     <= FILL_ONE;
            top_lcp_reg  <= '0;
            top_left_reg <= '0;
            ovf_reg      <= 1'b0;
            oval_reg     <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            fill_reg     <= fill_next;
            top_lcp_reg  <= top_lcp_next;
            top_left_reg <= top_left_next;
            ovf_reg      <= ovf_next;
            oval_reg     <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        last_reg   <= last_next;
        right_reg  <= right_next;
        lb_reg     <= lb_next;
        olcp_reg   <= olcp_next;
        oleft_reg  <= oleft_next;
        oright_reg <= oright_next;
        oend_reg   <= oend_next;
        oflag_reg  <= oflag_next;
    end

    assign out_valid        = oval_reg;
    assign interval_lcp     = olcp_reg;
    assign interval_left    = oleft_reg;
    assign interval_right   = oright_reg;
    assign run_end          = oend_reg;
    assign stack_overflowed = oflag_reg;

    // the root entry is always present and the fill never passes the depth
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != '0) && (fill_reg <= FILL_FULL))
        else $error("stack fill out of range");

    // every closed interval removes exactly one entry
    a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (fill_reg == $past(fill_reg) - FILL_ONE))
        else $error("pop did not lower the fill by one");

    // a new result never overwrites one that is still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && !out_ready) |-> !cmd.pop)
        else $error("result overwritten while stalled");

    // the overflow flag is sticky until reset
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

endmodule

>>> src/lcp_interval_enumerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_interval_enumerator
// bottom-up lcp interval traversal over a stream of lcp array entries
// ----------------------------------------------------------------------------
// output: the first closed interval of an entry is popped in the evaluate state
//   after the entry transfer and then registered; further intervals follow one
//   a cycle while the output register is free, a pace set by the one-pop-per-cycle
//   stack ram read port; s_tready is high only in idle, after the push or drop
// reset: stack holds the root only, position 1, overflow flag clear; no
//   clearing pass, stack entries are always written before they are read
module lcp_interval_enumerator (
    input  logic        clk,
    input  logic        rst_n,
    // entry input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] lcp_value
    input  logic        s_tlast,   // last_item
    // closed interval output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] interval_lcp, [31:16] interval_left,
                                   // [47:32] interval_right
    output logic        m_tlast,   // run_end
    output logic        m_tuser    // stack_overflowed
);

    import lie_pkg::*;

    lie_cmd_t    cmd;
    lie_status_t status;

    logic [OUT_WIDTH-1:0] interval_lcp;
    logic [OUT_WIDTH-1:0] interval_left;
    logic [OUT_WIDTH-1:0] interval_right;

    // sequencer: idle -> evaluate, which pops while the entry is below the
    // top lcp and then pushes or drops the new interval in its last cycle
    lie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // stack, position counter and the output register in front of m_*
    lie_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .lcp_value        (s_tdata[LCP_WIDTH-1:0]),
        .last_item        (s_tlast),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .interval_lcp     (interval_lcp),
        .interval_left    (interval_left),
        .interval_right   (interval_right),
        .run_end          (m_tlast),
        .stack_overflowed (m_tuser)
    );

    // fields packed from the lowest bit up
    assign m_tdata = {interval_right, interval_left, interval_lcp};

endmodule

>>> test/lcp_interval_enumerator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_interval_enumerator_tb
// self-checking bench for the lcp interval enumerator: an in-bench interval
// stack predicts every closed interval of each lcp entry transfer, and a
// monitor compares the output stream against it in order, under random
// stalls on both sides and a stack overflow run
// ----------------------------------------------------------------------------
module lcp_interval_enumerator_tb;

    import lie_pkg::*;

    localparam int IDLE_PCT      = 18;
    localparam int RANDOM_ITEMS  = 330;
    localparam int RAMP_AT       = 250;     // random items before the overflow ramp
    localparam int STUCK_LIMIT   = 2000;    // cycles with no transfer at all
    localparam int TAIL_CYCLES   = 20;
    localparam int REPORT_MAX    = 10;

    // one lcp array entry as the sender queues it
    typedef struct packed {
        logic [15:0] lcp;
        logic        last;
        logic        drain_first;   // sender waits for every result before this one
    } lcp_entry_t;

    // one closed interval as it leaves the block
    typedef struct packed {
        logic [15:0] lcp;
        logic [15:0] left;
        logic [15:0] right;
        logic        run_end;
        logic        ovf;
    } interval_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [15:0] lcp_value
    logic        s_tlast  = 1'b0;   // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [15:0] interval_lcp, [31:16] interval_left,
                                    // [47:32] interval_right
    logic        m_tlast;           // run_end
    logic        m_tuser;           // stack_overflowed

    lcp_entry_t  pending_entries[$];
    interval_t   closed_intervals[$];

    // predicted state of the interval stack
    logic [15:0] stk_lcp  [STACK_DEPTH] = '{default: '0};
    logic [15:0] stk_left [STACK_DEPTH] = '{default: '0};
    int          stk_fill    = 1;
    logic [15:0] cur_pos     = 16'd1;
    logic        ovf_sticky  = 1'b0;

    int          entries_accepted  = 0;
    int          intervals_checked = 0;
    int          runs_seen         = 0;
    int          deepest_fill      = 1;
    int          mismatches        = 0;
    int          stuck_cycles      = 0;
    logic        quiet;

    lcp_interval_enumerator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // a stretch of the random part where neither side idles
    assign quiet = (entries_accepted >= 150) && (entries_accepted < 260);

    // pops every interval the entry closes, then opens a new one if the
    // value rises above the surviving top; the new left bound is inherited
    // from the last interval closed, or position-1 when nothing closed
    task automatic close_and_open(input logic [15:0] value, input logic fin);
        interval_t   batch[$];
        interval_t   iv;
        logic [15:0] right_bound;
        logic [15:0] left_carry;
        right_bound = cur_pos - 16'd1;
        left_carry  = right_bound;
        while (stk_fill > 1 && value < stk_lcp[stk_fill-1])
        begin
            iv.lcp     = stk_lcp[stk_fill-1];
            iv.left    = stk_left[stk_fill-1];
            iv.right   = right_bound;
            iv.run_end = 1'b0;
            iv.ovf     = 1'b0;
            left_carry = stk_left[stk_fill-1];
            batch.push_back(iv);
            stk_fill--;
        end
        if (value > stk_lcp[stk_fill-1])
        begin
            // a full stack drops the push and latches the flag for good
            if (stk_fill < STACK_DEPTH)
            begin
                stk_lcp[stk_fill]  = value;
                stk_left[stk_fill] = left_carry;
                stk_fill++;
                if (stk_fill > deepest_fill)
                    deepest_fill = stk_fill;
            end
            else
            begin
                ovf_sticky = 1'b1;
            end
        end
        // flag reflects the state after this entry; run_end marks its last pop
        foreach (batch[i])
        begin
            batch[i].ovf     = ovf_sticky;
            batch[i].run_end = (i == batch.size() - 1);
            closed_intervals.push_back(batch[i]);
        end
        // end of run drops whatever is still open
        if (fin)
        begin
            stk_fill = 1;
            cur_pos  = 16'd1;
            runs_seen++;
        end
        else
        begin
            cur_pos = cur_pos + 16'd1;
        end
    endtask

    task automatic queue_entry(input logic [15:0] value, input logic fin,
                               input logic drain);
        lcp_entry_t e;
        e.lcp         = value;
        e.last        = fin;
        e.drain_first = drain;
        pending_entries.push_back(e);
    endtask

    // driver: keeps valid up until the transfer, idles only between entries
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                close_and_open(s_tdata, s_tlast);
                entries_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_entries.size() != 0
                        && !(pending_entries[0].drain_first && closed_intervals.size() != 0)
                        && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_entries[0].lcp;
                    s_tlast  <= pending_entries[0].last;
                    void'(pending_entries.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, in-order compare against the prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (closed_intervals.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected interval: lcp %0d left %0d right %0d end %b ovf %b",
                                 m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                                 m_tlast, m_tuser);
                end
                else
                begin
                    if (closed_intervals[0].lcp     !== m_tdata[15:0]
                     || closed_intervals[0].left    !== m_tdata[31:16]
                     || closed_intervals[0].right   !== m_tdata[47:32]
                     || closed_intervals[0].run_end !== m_tlast
                     || closed_intervals[0].ovf     !== m_tuser)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("interval %0d mismatch: expected lcp %0d left %0d right %0d",
                                     intervals_checked,
                                     closed_intervals[0].lcp, closed_intervals[0].left,
                                     closed_intervals[0].right);
                            $display("  expected end %b ovf %b", closed_intervals[0].run_end,
                                     closed_intervals[0].ovf);
                            $display("  got lcp %0d left %0d right %0d end %b ovf %b",
                                     m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                                     m_tlast, m_tuser);
                        end
                    end
                    void'(closed_intervals.pop_front());
                end
                intervals_checked++;
            end
            m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: a hung handshake on both sides ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("no transfer for %0d cycles", STUCK_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          random_items;
        int          run_len;
        int          flavor;
        int          walk;
        logic        ramp_done;
        logic [15:0] value;

        random_items = 0;
        ramp_done    = 1'b0;

        // directed: lone entry, extreme lcp, nesting with ties, run ending
        // with intervals still open, a later rise after a close
        queue_entry(16'd0, 1'b1, 1'b0);
        queue_entry(16'hFFFF, 1'b0, 1'b0);
        queue_entry(16'd0, 1'b1, 1'b0);
        queue_entry(16'd1, 1'b0, 1'b0);
        queue_entry(16'd3, 1'b0, 1'b0);
        queue_entry(16'd3, 1'b0, 1'b0);
        queue_entry(16'd2, 1'b0, 1'b0);
        queue_entry(16'd5, 1'b0, 1'b0);
        queue_entry(16'd1, 1'b0, 1'b0);
        queue_entry(16'd0, 1'b1, 1'b0);
        queue_entry(16'd4, 1'b0, 1'b0);
        queue_entry(16'd4, 1'b1, 1'b0);
        queue_entry(16'd2, 1'b0, 1'b0);
        queue_entry(16'd9, 1'b0, 1'b0);
        queue_entry(16'd7, 1'b0, 1'b0);
        queue_entry(16'h8000, 1'b0, 1'b0);
        queue_entry(16'd0, 1'b1, 1'b0);

        // random runs, mostly lcp-like walks that nest a few levels deep
        while (random_items < RANDOM_ITEMS)
        begin
            // one ramp past the stack depth: overflow, then a full unwind
            if (!ramp_done && random_items >= RAMP_AT)
            begin
                for (int v = 1; v <= STACK_DEPTH + 1; v++)
                    queue_entry(16'(v), 1'b0, v == 1);
                queue_entry(16'd0, 1'b1, 1'b0);
                ramp_done = 1'b1;
            end
            run_len = $urandom_range(1, 40);
            flavor  = $urandom_range(99);
            walk    = $urandom_range(0, 4);
            for (int k = 0; k < run_len; k++)
            begin
                if (flavor < 70)
                begin
                    walk = walk + $urandom_range(0, 6) - 3;
                    if (walk < 0)
                        walk = 0;
                    value = 16'(walk);
                end
                else if (flavor < 85)
                begin
                    case ($urandom_range(3))
                        0:       value = 16'd0;
                        1:       value = 16'hFFFF;
                        2:       value = 16'($urandom);
                        default: value = 16'($urandom_range(0, 8));
                    endcase
                end
                else
                begin
                    value = 16'($urandom);
                end
                queue_entry(value, k == run_len - 1, random_items == 0);
                random_items++;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_entries.size() != 0 || s_tvalid)
            @(posedge clk);
        while (closed_intervals.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d lcp entries in %0d runs, %0d closed intervals checked",
                 entries_accepted, runs_seen, intervals_checked);
        $display("deepest stack %0d of %0d, overflow hit %b",
                 deepest_fill, STACK_DEPTH, ovf_sticky);
        if (mismatches == 0 && closed_intervals.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d mismatches, %0d intervals never seen",
                     mismatches, closed_intervals.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> sim.f
src/lie_pkg.sv
src/lie_ram.sv
src/lie_ctrl.sv
src/lie_datapath.sv
src/lcp_interval_enumerator.sv
test/lcp_interval_enumerator_tb.sv
